@@ src/srcu_pkg.sv @@
package srcu_pkg;

  localparam int COORD_W    = 32;
  localparam int SIZE_W     = COORD_W - 1;
  localparam int LEVEL_W    = 6;
  // Differences of points and far edges need two bits beyond a coordinate.
  localparam int DIFF_W     = COORD_W + 2;
  localparam int MUL_LO_W   = DIFF_W / 2;
  localparam int MUL_HI_W   = DIFF_W - MUL_LO_W;
  localparam int PP_LO_W    = DIFF_W + MUL_LO_W + 1;
  localparam int PP_HI_W    = DIFF_W + MUL_HI_W;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int NUM_STAGES = 6;
  localparam int NUM_MUL    = 8;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEG_START_X = 2'd0,
    REG_SEG_START_Y = 2'd1,
    REG_SEG_END_X   = 2'd2,
    REG_SEG_END_Y   = 2'd3
  } srcu_reg_t;

  typedef enum logic [1:0] {
    CLS_NOT_WITHIN = 2'd0,
    CLS_PARTLY     = 2'd1,
    CLS_FULLY      = 2'd2
  } srcu_class_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rect_x;
    logic signed [COORD_W-1:0] rect_y;
    logic [SIZE_W-1:0]         extent_x;
    logic [SIZE_W-1:0]         extent_y;
    logic [LEVEL_W-1:0]        tree_level;
  } srcu_in_t;

  typedef struct packed {
    srcu_class_t        within_class;
    logic               intersects;
    logic [LEVEL_W-1:0] score;
  } srcu_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } srcu_seg_t;

  // Load enables of the pipeline stages, from input register to result register.
  typedef struct packed {
    logic in_reg;
    logic diff;
    logic part;
    logic prod;
    logic cross_sub;
    logic result;
  } srcu_adv_t;

  typedef struct packed {
    logic pp;
    logic sum;
  } srcu_mul_en_t;

endpackage

@@ src/srcu_mul.sv @@
module srcu_mul (
  input  logic                                clk,
  input  srcu_pkg::srcu_mul_en_t              en,
  input  logic signed [srcu_pkg::DIFF_W-1:0]  a,
  input  logic signed [srcu_pkg::DIFF_W-1:0]  b,
  output logic signed [srcu_pkg::PROD_W-1:0]  prod
);
  import srcu_pkg::*;

  logic signed [MUL_LO_W:0]     b_lo;
  logic signed [MUL_HI_W-1:0]   b_hi;
  logic signed [PP_LO_W-1:0]    pp_lo_nxt;
  logic signed [PP_HI_W-1:0]    pp_hi_nxt;
  logic signed [PP_LO_W-1:0]    pp_lo_r;
  logic signed [PP_HI_W-1:0]    pp_hi_r;
  logic signed [PROD_W-1:0]     prod_nxt;
  logic signed [PROD_W-1:0]     prod_r;

  // The low half of b is taken as an unsigned digit, the high half carries the sign.
  assign b_lo = $signed({1'b0, b[MUL_LO_W-1:0]});
  assign b_hi = $signed(b[DIFF_W-1:MUL_LO_W]);

  assign pp_lo_nxt = PP_LO_W'(a) * PP_LO_W'(b_lo);
  assign pp_hi_nxt = PP_HI_W'(a) * PP_HI_W'(b_hi);
  assign prod_nxt  = (PROD_W'(pp_hi_r) <<< MUL_LO_W) + PROD_W'(pp_lo_r);

  always_ff @(posedge clk) begin
    if (en.pp) begin
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
    end
    if (en.sum) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

@@ src/srcu_core.sv @@
module srcu_core (
  input  logic                 clk,
  input  srcu_pkg::srcu_adv_t  adv,
  input  srcu_pkg::srcu_seg_t  seg,
  input  srcu_pkg::srcu_in_t   in_data,
  output srcu_pkg::srcu_out_t  out_data
);
  import srcu_pkg::*;

  typedef struct packed {
    logic               in_a;
    logic               in_b;
    logic [LEVEL_W-1:0] level;
  } flags_t;

  // The segment crosses a diagonal when both parameters lie in [0, 1], tested
  // against the denominator's sign without dividing.
  function automatic logic seg_cross(input logic signed [CROSS_W-1:0] den,
                                     input logic signed [CROSS_W-1:0] nt,
                                     input logic signed [CROSS_W-1:0] nu);
    logic hit;
    if (den > 0) begin
      hit = (nt >= 0) && (nt <= den) && (nu >= 0) && (nu <= den);
    end else if (den < 0) begin
      hit = (nt <= 0) && (nt >= den) && (nu <= 0) && (nu >= den);
    end else begin
      hit = 1'b0;
    end
    return hit;
  endfunction

  srcu_in_t                  item_r;
  logic signed [DIFF_W-1:0]  ax, ay, bx, by, x0, y0, x1, y1, w, h;
  logic                      in_a, in_b;
  logic signed [DIFF_W-1:0]  rx_r, ry_r, qx_r, qy1_r, qy2_r, w_r, h_r;
  flags_t                    flags1_r, flags2_r, flags3_r, flags4_r;
  logic signed [DIFF_W-1:0]  mul_a [NUM_MUL];
  logic signed [DIFF_W-1:0]  mul_b [NUM_MUL];
  logic signed [PROD_W-1:0]  prod  [NUM_MUL];
  logic signed [CROSS_W-1:0] p     [NUM_MUL];
  logic signed [CROSS_W-1:0] den1_r, nt1_r, nu1_r, den2_r, nt2_r, nu2_r;
  logic                      cross1, cross2;
  srcu_out_t                 out_nxt;
  srcu_out_t                 out_r;
  srcu_mul_en_t              mul_en;

  assign ax = DIFF_W'(seg.start_x);
  assign ay = DIFF_W'(seg.start_y);
  assign bx = DIFF_W'(seg.end_x);
  assign by = DIFF_W'(seg.end_y);
  assign x0 = DIFF_W'(item_r.rect_x);
  assign y0 = DIFF_W'(item_r.rect_y);
  assign w  = $signed(DIFF_W'(item_r.extent_x));
  assign h  = $signed(DIFF_W'(item_r.extent_y));
  assign x1 = x0 + w;
  assign y1 = y0 + h;

  // Closed rectangle: a point on an edge counts as inside.
  assign in_a = (ax >= x0) && (ax <= x1) && (ay >= y0) && (ay <= y1);
  assign in_b = (bx >= x0) && (bx <= x1) && (by >= y0) && (by <= y1);

  always_ff @(posedge clk) begin
    if (adv.in_reg) begin
      item_r <= in_data;
    end
    if (adv.diff) begin
      rx_r     <= bx - ax;
      ry_r     <= by - ay;
      qx_r     <= x0 - ax;
      qy1_r    <= y0 - ay;
      qy2_r    <= y1 - ay;
      w_r      <= w;
      h_r      <= h;
      flags1_r <= '{in_a: in_a, in_b: in_b, level: item_r.tree_level};
    end
    if (adv.part) begin
      flags2_r <= flags1_r;
    end
    if (adv.prod) begin
      flags3_r <= flags2_r;
    end
  end

  // Products for both diagonals, several shared between them; the second diagonal
  // runs from the (x0, y1) corner to the (x1, y0) corner, so its direction is (w, -h).
  assign mul_a[0] = rx_r;  assign mul_b[0] = h_r;
  assign mul_a[1] = ry_r;  assign mul_b[1] = w_r;
  assign mul_a[2] = qx_r;  assign mul_b[2] = h_r;
  assign mul_a[3] = qy1_r; assign mul_b[3] = w_r;
  assign mul_a[4] = qx_r;  assign mul_b[4] = ry_r;
  assign mul_a[5] = qy1_r; assign mul_b[5] = rx_r;
  assign mul_a[6] = qy2_r; assign mul_b[6] = w_r;
  assign mul_a[7] = qy2_r; assign mul_b[7] = rx_r;

  assign mul_en = '{pp: adv.part, sum: adv.prod};

  for (genvar i = 0; i < NUM_MUL; i++) begin : g_mul
    srcu_mul u_mul (
      .clk  (clk),
      .en   (mul_en),
      .a    (mul_a[i]),
      .b    (mul_b[i]),
      .prod (prod[i])
    );
    assign p[i] = CROSS_W'(prod[i]);
  end

  always_ff @(posedge clk) begin
    if (adv.cross_sub) begin
      den1_r   <= p[0] - p[1];
      nt1_r    <= p[2] - p[3];
      nu1_r    <= p[4] - p[5];
      den2_r   <= -(p[0] + p[1]);
      nt2_r    <= -(p[2] + p[6]);
      nu2_r    <= p[4] - p[7];
      flags4_r <= flags3_r;
    end
  end

  assign cross1 = seg_cross(den1_r, nt1_r, nu1_r);
  assign cross2 = seg_cross(den2_r, nt2_r, nu2_r);

  always_comb begin
    if (flags4_r.in_a && flags4_r.in_b) begin
      out_nxt.within_class = CLS_FULLY;
    end else if (flags4_r.in_a || flags4_r.in_b || cross1 || cross2) begin
      out_nxt.within_class = CLS_PARTLY;
    end else begin
      out_nxt.within_class = CLS_NOT_WITHIN;
    end
    out_nxt.intersects = (out_nxt.within_class != CLS_NOT_WITHIN);
    out_nxt.score      = flags4_r.level;
  end

  always_ff @(posedge clk) begin
    if (adv.result) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

@@ src/segment_rectangle_classifier_unit.sv @@
// Classifies axis-aligned rectangles against a line segment held in four
// configuration registers: not within, partly within (one endpoint inside or
// the segment crosses a diagonal) or fully within (both endpoints inside).
// The unit accepts one rectangle request per cycle when the output is not
// stalled; the depth of its pipeline is set by the input register, the
// difference stage, the two-step split multipliers for the cross products,
// the cross-product subtract stage and the result register.
// A stalled output backs up the pipeline, and bubbles are squeezed out.
// Segment registers may be written only while no request is in flight.
module segment_rectangle_classifier_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  srcu_pkg::srcu_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output srcu_pkg::srcu_out_t                out_data,
  input  logic                               cfg_we,
  input  logic [srcu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srcu_pkg::COORD_W-1:0]       cfg_wdata
);
  import srcu_pkg::*;

  srcu_seg_t             seg_r;
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] adv_vec;
  srcu_adv_t             adv;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    adv_vec[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv_vec[k] = !valid_r[k] || adv_vec[k+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (adv_vec[0]) begin
      valid_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv_vec[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      seg_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SEG_START_X: seg_r.start_x <= $signed(cfg_wdata);
          REG_SEG_START_Y: seg_r.start_y <= $signed(cfg_wdata);
          REG_SEG_END_X:   seg_r.end_x   <= $signed(cfg_wdata);
          REG_SEG_END_Y:   seg_r.end_y   <= $signed(cfg_wdata);
          default:         seg_r         <= seg_r;
        endcase
      end
    end
  end

  assign adv = '{in_reg: adv_vec[0], diff: adv_vec[1], part: adv_vec[2],
                 prod: adv_vec[3], cross_sub: adv_vec[4], result: adv_vec[5]};

  srcu_core u_core (
    .clk      (clk),
    .adv      (adv),
    .seg      (seg_r),
    .in_data  (in_data),
    .out_data (out_data)
  );

  assign in_ready  = adv_vec[0];
  assign out_valid = valid_r[NUM_STAGES-1];

`ifndef ASSERT_OFF
  a_intersects_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.intersects == (out_data.within_class != CLS_NOT_WITHIN)))
    else $error("intersects disagrees with within_class");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && (&valid_r)))
    else $error("input held off while the pipeline has room");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> valid_r[0])
    else $error("accepted request did not enter the input register");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!valid_r[NUM_STAGES-2] && adv_vec[NUM_STAGES-1]) |=> !out_valid)
    else $error("result appeared without a request behind it");
`endif

endmodule
